/* hw/rtl/mirrored_address_range_decoder_unit_assert.svh */
// assertion macros shared by the decoder's checker
`ifndef MIRRORED_ADDRESS_RANGE_DECODER_UNIT_ASSERT_SVH
`define MIRRORED_ADDRESS_RANGE_DECODER_UNIT_ASSERT_SVH

// clocked assertion, switched off while reset is held
`define MADR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// clocked assertion that also holds through reset
`define MADR_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

/* hw/rtl/madr_pkg.sv */
// package: table sizes, codes and shared types of the address decoder
package madr_pkg;

    localparam int REGION_ENTRIES = 8;
    localparam int MIRROR_ENTRIES = 16;

    localparam int REG_IDX_W = (REGION_ENTRIES > 1) ? $clog2(REGION_ENTRIES) : 1;
    localparam int REG_CNT_W = $clog2(REGION_ENTRIES + 1);
    localparam int MIR_IDX_W = (MIRROR_ENTRIES > 1) ? $clog2(MIRROR_ENTRIES) : 1;
    localparam int MIR_CNT_W = $clog2(MIRROR_ENTRIES + 1);

    // operation codes
    localparam logic [1:0] MODE_ADD_REGION = 2'd0;
    localparam logic [1:0] MODE_ADD_MIRROR = 2'd1;

    // result status codes
    localparam logic [2:0] ST_ADDED      = 3'd0;
    localparam logic [2:0] ST_TRANSLATED = 3'd1;
    localparam logic [2:0] ST_UNMAPPED   = 3'd2;
    localparam logic [2:0] ST_FULL       = 3'd3;
    localparam logic [2:0] ST_INVERTED   = 3'd4;

    typedef logic [15:0] t_addr;
    typedef logic [16:0] t_len;

    typedef struct packed {
        logic  we;
        t_addr start;
        t_addr length;
    } t_reg_wr;

    typedef struct packed {
        logic  we;
        t_addr source;
        t_addr target;
        t_len  length;
    } t_mir_wr;

    typedef struct packed {
        t_addr start;
        t_addr length;
    } t_reg_rd;

    typedef struct packed {
        t_addr source;
        t_addr target;
        t_len  length;
    } t_mir_rd;

    typedef struct packed {
        logic [2:0] status;
        logic [2:0] region_index;
        t_addr      offset;
        t_addr      folded_address;
    } t_result;

endpackage

/* hw/rtl/madr_in_if.sv */
// request channel of the address decoder
interface madr_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [15:0] address;
    logic [15:0] region_size;
    logic [15:0] source_end;
    logic [15:0] mirror_start;
    logic [15:0] mirror_end;

    modport source (output valid, mode, address, region_size, source_end,
                    mirror_start, mirror_end, input ready);
    modport sink   (input valid, mode, address, region_size, source_end,
                    mirror_start, mirror_end, output ready);
endinterface

/* hw/rtl/madr_out_if.sv */
// result channel of the address decoder
interface madr_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [2:0]  region_index;
    logic [15:0] offset;
    logic [15:0] folded_address;

    modport source (output valid, status, region_index, offset, folded_address,
                    input ready);
    modport sink   (input valid, status, region_index, offset, folded_address,
                     output ready);
endinterface

/* hw/rtl/madr_range_unit.sv */
// shared range unit: tests base <= value < base + length and gives value - base
module madr_range_unit
    import madr_pkg::*;
(
    input  t_addr i_value,
    input  t_addr i_base,
    input  t_len  i_length,
    output logic  o_hit,
    output t_addr o_diff
);

    logic [16:0] w_end;

    // end of range in 17 bits so it never wraps
    assign w_end  = {1'b0, i_base} + i_length;
    assign o_hit  = (i_value >= i_base) && ({1'b0, i_value} < w_end);
    assign o_diff = i_value - i_base;

endmodule

/* hw/rtl/madr_tables.sv */
// region and mirror tables with append-only writes and fill counts
module madr_tables
    import madr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_reg_wr              i_reg_wr,
    input  t_mir_wr              i_mir_wr,
    input  logic [REG_IDX_W-1:0] i_reg_idx,
    input  logic [MIR_IDX_W-1:0] i_mir_idx,
    output t_reg_rd              o_reg_rd,
    output t_mir_rd              o_mir_rd,
    output logic [REG_CNT_W-1:0] o_reg_count,
    output logic [MIR_CNT_W-1:0] o_mir_count
);

    t_reg_rd              r_reg_tab [REGION_ENTRIES];
    t_mir_rd              r_mir_tab [MIRROR_ENTRIES];
    logic [REG_CNT_W-1:0] r_reg_count;
    logic [MIR_CNT_W-1:0] r_mir_count;

    // fill counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reg_count <= '0;
            r_mir_count <= '0;
        end else begin
            if (i_reg_wr.we) begin
                r_reg_count <= r_reg_count + REG_CNT_W'(1);
            end
            if (i_mir_wr.we) begin
                r_mir_count <= r_mir_count + MIR_CNT_W'(1);
            end
        end
    end

    // entries are appended at the current count
    always_ff @(posedge i_clk) begin
        if (i_reg_wr.we) begin
            r_reg_tab[r_reg_count[REG_IDX_W-1:0]] <= '{start: i_reg_wr.start,
                                                      length: i_reg_wr.length};
        end
        if (i_mir_wr.we) begin
            r_mir_tab[r_mir_count[MIR_IDX_W-1:0]] <= '{source: i_mir_wr.source,
                                                      target: i_mir_wr.target,
                                                      length: i_mir_wr.length};
        end
    end

    assign o_reg_rd    = r_reg_tab[i_reg_idx];
    assign o_mir_rd    = r_mir_tab[i_mir_idx];
    assign o_reg_count = r_reg_count;
    assign o_mir_count = r_mir_count;

endmodule

/* hw/rtl/mirrored_address_range_decoder_unit.sv */
// Programmable address decoder with mirroring. One request is handled at a time and
// the request channel is ready only while the sequencer is idle. Adding a region or
// rejecting an inverted or full request goes from the idle state straight to the done
// state. Adding a mirror range appends one table entry per cycle, at most 16 entries
// in all, until the span is covered or the table is full. A translation walks the
// mirror table and then the region table one entry per cycle through a single shared
// range compare unit; the walk of a table ends at its first hit or at its fill count.
// A finished result sits in an output register until the result transfer; the next
// request can be taken while it waits.
module mirrored_address_range_decoder_unit
    import madr_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    madr_in_if.sink       i_in,
    madr_out_if.source    o_out
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MIR_ADD,
        S_FOLD,
        S_REGION,
        S_DONE
    } t_state;

    t_state               r_state, n_state;
    t_addr                r_addr, n_addr;
    t_len                 r_size, n_size;
    t_len                 r_remain, n_remain;
    t_addr                r_target, n_target;
    logic [MIR_CNT_W-1:0] r_mi, n_mi;
    logic [REG_CNT_W-1:0] r_ri, n_ri;
    t_addr                r_fold, n_fold;
    t_result              r_res, n_res;
    logic                 r_out_valid, n_out_valid;
    t_result              r_out, n_out;

    t_reg_wr              w_reg_wr;
    t_mir_wr              w_mir_wr;
    t_reg_rd              w_reg_rd;
    t_mir_rd              w_mir_rd;
    logic [REG_CNT_W-1:0] w_reg_count;
    logic [MIR_CNT_W-1:0] w_mir_count;
    t_addr                w_value, w_base, w_diff;
    t_len                 w_len, w_piece;
    logic                 w_hit, w_accept, w_inverted;

    // tables
    madr_tables u_tables (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_reg_wr    (w_reg_wr),
        .i_mir_wr    (w_mir_wr),
        .i_reg_idx   (r_ri[REG_IDX_W-1:0]),
        .i_mir_idx   (r_mi[MIR_IDX_W-1:0]),
        .o_reg_rd    (w_reg_rd),
        .o_mir_rd    (w_mir_rd),
        .o_reg_count (w_reg_count),
        .o_mir_count (w_mir_count)
    );

    // shared range unit: mirror targets while folding, region starts afterwards
    assign w_value = (r_state == S_FOLD) ? r_addr : r_fold;
    assign w_base  = (r_state == S_FOLD) ? w_mir_rd.target : w_reg_rd.start;
    assign w_len   = (r_state == S_FOLD) ? w_mir_rd.length : {1'b0, w_reg_rd.length};

    madr_range_unit u_range (
        .i_value  (w_value),
        .i_base   (w_base),
        .i_length (w_len),
        .o_hit    (w_hit),
        .o_diff   (w_diff)
    );

    // handshake and request checks
    assign w_accept   = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign w_inverted = (i_in.source_end < i_in.address) ||
                        (i_in.mirror_end < i_in.mirror_start);
    assign w_piece    = (r_remain < r_size) ? r_remain : r_size;

    // table writes
    always_comb begin
        w_reg_wr        = '0;
        w_reg_wr.we     = w_accept && (i_in.mode == MODE_ADD_REGION) &&
                          (w_reg_count < REG_CNT_W'(REGION_ENTRIES));
        w_reg_wr.start  = i_in.address;
        w_reg_wr.length = i_in.region_size;
        w_mir_wr        = '0;
        w_mir_wr.we     = (r_state == S_MIR_ADD) && (r_remain != '0) &&
                          (w_mir_count < MIR_CNT_W'(MIRROR_ENTRIES));
        w_mir_wr.source = r_addr;
        w_mir_wr.target = r_target;
        w_mir_wr.length = w_piece;
    end

    // sequencer next state
    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_size      = r_size;
        n_remain    = r_remain;
        n_target    = r_target;
        n_mi        = r_mi;
        n_ri        = r_ri;
        n_fold      = r_fold;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        // result register frees on transfer
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_addr = i_in.address;
                    n_res  = '0;
                    case (i_in.mode)
                        MODE_ADD_REGION: begin
                            n_state = S_DONE;
                            if (w_reg_wr.we) begin
                                n_res.status       = ST_ADDED;
                                n_res.region_index = 3'(w_reg_count);
                            end else begin
                                n_res.status = ST_FULL;
                            end
                        end
                        MODE_ADD_MIRROR: begin
                            if (w_inverted) begin
                                n_res.status = ST_INVERTED;
                                n_state      = S_DONE;
                            end else begin
                                n_size   = {1'b0, i_in.source_end} -
                                           {1'b0, i_in.address} + 17'd1;
                                n_remain = {1'b0, i_in.mirror_end} -
                                           {1'b0, i_in.mirror_start} + 17'd1;
                                n_target = i_in.mirror_start;
                                n_state  = S_MIR_ADD;
                            end
                        end
                        default: begin
                            n_mi    = '0;
                            n_state = S_FOLD;
                        end
                    endcase
                end
            end
            // one mirror piece per cycle
            S_MIR_ADD: begin
                if (r_remain == '0) begin
                    n_res.status = ST_ADDED;
                    n_state      = S_DONE;
                end else if (!w_mir_wr.we) begin
                    n_res.status = ST_FULL;
                    n_state      = S_DONE;
                end else begin
                    n_remain = r_remain - w_piece;
                    n_target = r_target + r_size[15:0];
                end
            end
            // first covering mirror entry folds the address back to its source
            S_FOLD: begin
                if (r_mi >= w_mir_count) begin
                    n_fold  = r_addr;
                    n_ri    = '0;
                    n_state = S_REGION;
                end else if (w_hit) begin
                    n_fold  = w_mir_rd.source + w_diff;
                    n_ri    = '0;
                    n_state = S_REGION;
                end else begin
                    n_mi = r_mi + MIR_CNT_W'(1);
                end
            end
            // first covering region gives index and offset
            S_REGION: begin
                n_res.folded_address = r_fold;
                if (r_ri >= w_reg_count) begin
                    n_res.status = ST_UNMAPPED;
                    n_state      = S_DONE;
                end else if (w_hit) begin
                    n_res.status       = ST_TRANSLATED;
                    n_res.region_index = 3'(r_ri);
                    n_res.offset       = w_diff;
                    n_state            = S_DONE;
                end else begin
                    n_ri = r_ri + REG_CNT_W'(1);
                end
            end
            // hand the result to the output register once it is free
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_addr   <= n_addr;
        r_size   <= n_size;
        r_remain <= n_remain;
        r_target <= n_target;
        r_mi     <= n_mi;
        r_ri     <= n_ri;
        r_fold   <= n_fold;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_out.status;
    assign o_out.region_index   = r_out.region_index;
    assign o_out.offset         = r_out.offset;
    assign o_out.folded_address = r_out.folded_address;

endmodule

/* hw/rtl/madr_checker.sv */
// port-level checker for the address decoder, bound to the top level
`include "mirrored_address_range_decoder_unit_assert.svh"

module madr_checker
    import madr_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_status,
    input logic [15:0] i_offset,
    input logic [15:0] i_folded_address
);

    // a result stays offered until its transfer
    `MADR_ASSERT(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> i_out_valid, "result dropped while stalled")

    // the sequencer is busy in the cycle after a request transfer
    `MADR_ASSERT(a_busy_after_req, i_clk, i_rst_n, (i_in_valid && i_in_ready) |=> !i_in_ready, "request taken while busy")

    // only a translation carries an offset
    `MADR_ASSERT(a_offset_zero, i_clk, i_rst_n, (i_out_valid && i_status != ST_TRANSLATED) |-> (i_offset == 16'd0), "offset without translation")

    // table updates report no folded address
    `MADR_ASSERT(a_fold_zero, i_clk, i_rst_n, (i_out_valid && (i_status == ST_ADDED || i_status == ST_FULL || i_status == ST_INVERTED)) |-> (i_folded_address == 16'd0), "folded address on table update")

    // reset empties the result register
    `MADR_ASSERT_RST(a_reset_empty, i_clk, !i_rst_n |=> !i_out_valid, "result valid after reset")

endmodule

bind mirrored_address_range_decoder_unit madr_checker u_madr_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_status         (o_out.status),
    .i_offset         (o_out.offset),
    .i_folded_address (o_out.folded_address)
);

/* dv/testbench.sv */
// self-checking testbench for the mirrored address range decoder
module testbench
    import madr_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // translation is decoded from the high mode bit, so both codes translate
    localparam logic [1:0] MODE_TRANSLATE       = 2'd2;
    localparam logic [1:0] MODE_TRANSLATE_ALIAS = 2'd3;

    localparam int unsigned RANDOM_ITEMS    = 680;
    localparam int unsigned HOLD_OFF_AT     = 150;
    localparam int unsigned HOLD_OFF_CYCLES = 250;
    localparam int unsigned DRAIN_CYCLES    = 64;
    localparam int unsigned RUN_LIMIT       = 200000;
    localparam int unsigned MAX_REPORTS     = 10;

    typedef struct packed {
        logic [1:0] mode;
        t_addr      address;
        t_addr      region_size;
        t_addr      source_end;
        t_addr      mirror_start;
        t_addr      mirror_end;
    } t_request;

    // shadow copy of both tables plus the queue of results still owed by the block
    class decode_scoreboard;
        t_addr       region_base [REGION_ENTRIES];
        t_addr       region_len  [REGION_ENTRIES];
        int unsigned region_used;
        t_addr       mirror_src  [MIRROR_ENTRIES];
        t_addr       mirror_dst  [MIRROR_ENTRIES];
        t_len        mirror_len  [MIRROR_ENTRIES];
        int unsigned mirror_used;
        t_result     owed_results[$];
        int unsigned failures;

        function void report(string what, t_result want, t_result got);
            failures++;
            if (failures <= MAX_REPORTS) begin
                $display("%s: expected st=%0d idx=%0d off=%h fold=%h, got st=%0d idx=%0d off=%h fold=%h",
                         what, want.status, want.region_index, want.offset,
                         want.folded_address, got.status, got.region_index, got.offset,
                         got.folded_address);
            end
        endfunction

        // work out the result of an accepted request and update the tables
        function void note_request(t_request r);
            t_result     res;
            int unsigned piece_len, span, whole, rem, pieces, k, addr, t;
            bit          dropped, found;
            res = '0;
            if (r.mode == MODE_ADD_REGION) begin
                if (region_used >= REGION_ENTRIES) begin
                    res.status = ST_FULL;
                end else begin
                    region_base[region_used] = r.address;
                    region_len[region_used]  = r.region_size;
                    res.status       = ST_ADDED;
                    res.region_index = 3'(region_used);
                    region_used++;
                end
            end else if (r.mode == MODE_ADD_MIRROR) begin
                if (r.source_end < r.address || r.mirror_end < r.mirror_start) begin
                    res.status = ST_INVERTED;
                end else begin
                    // whole copies of the source first, then the partial piece
                    piece_len = 32'(r.source_end) - 32'(r.address) + 1;
                    span      = 32'(r.mirror_end) - 32'(r.mirror_start) + 1;
                    whole     = span / piece_len;
                    rem       = span % piece_len;
                    pieces    = whole + ((rem != 0) ? 1 : 0);
                    dropped   = 1'b0;
                    for (k = 0; k < pieces; k++) begin
                        if (mirror_used >= MIRROR_ENTRIES) begin
                            dropped = 1'b1;
                            break;
                        end
                        mirror_src[mirror_used] = r.address;
                        mirror_dst[mirror_used] = t_addr'(32'(r.mirror_start) + k * piece_len);
                        mirror_len[mirror_used] = t_len'((k < whole) ? piece_len : rem);
                        mirror_used++;
                    end
                    res.status = dropped ? ST_FULL : ST_ADDED;
                end
            end else begin
                // fold through the first covering mirror entry
                addr  = r.address;
                found = 1'b0;
                for (k = 0; k < mirror_used && !found; k++) begin
                    t = mirror_dst[k];
                    if (addr >= t && addr < t + mirror_len[k]) begin
                        addr  = (32'(mirror_src[k]) + addr - t) & 32'hFFFF;
                        found = 1'b1;
                    end
                end
                res.status         = ST_UNMAPPED;
                res.folded_address = t_addr'(addr);
                // then the first region that covers the folded address
                found = 1'b0;
                for (k = 0; k < region_used && !found; k++) begin
                    if (addr >= region_base[k] &&
                        addr < 32'(region_base[k]) + 32'(region_len[k])) begin
                        res.status       = ST_TRANSLATED;
                        res.region_index = 3'(k);
                        res.offset       = t_addr'(addr - region_base[k]);
                        found = 1'b1;
                    end
                end
            end
            owed_results.push_back(res);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (owed_results.size() == 0) begin
                report("result with no request pending", '0, got);
                return;
            end
            want = owed_results.pop_front();
            if (got.status !== want.status || got.region_index !== want.region_index ||
                got.offset !== want.offset || got.folded_address !== want.folded_address) begin
                report("result mismatch", want, got);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    madr_in_if  in_ch ();
    madr_out_if out_ch ();

    mirrored_address_range_decoder_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    decode_scoreboard sb;
    int unsigned      requests_sent;
    int unsigned      results_seen;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_request compose_request(logic [1:0] m, t_addr a, t_addr sz,
                                                 t_addr se, t_addr ms, t_addr me);
        t_request r;
        r.mode         = m;
        r.address      = a;
        r.region_size  = sz;
        r.source_end   = se;
        r.mirror_start = ms;
        r.mirror_end   = me;
        return r;
    endfunction

    function automatic t_request random_request(logic [1:0] m);
        return compose_request(m, t_addr'($urandom), t_addr'($urandom), t_addr'($urandom),
                               t_addr'($urandom), t_addr'($urandom));
    endfunction

    // region sizes lean small, with empty regions now and then
    function automatic t_request make_region_request();
        t_request    r;
        int unsigned pick;
        r    = random_request(MODE_ADD_REGION);
        pick = $urandom_range(0, 7);
        if (pick == 0) begin
            r.region_size = '0;
        end else if (pick < 4) begin
            r.region_size = t_addr'($urandom_range(1, 256));
        end else if (pick < 6) begin
            r.region_size = t_addr'($urandom_range(1, 4096));
        end
        return r;
    endfunction

    // well-formed mirror spans of a few pieces, sourced at a region half the time one exists;
    // a tenth keep raw fields, so inverted and very long spans turn up
    function automatic t_request make_mirror_request();
        t_request    r;
        int unsigned pick, size, base, whole, rem, span;
        r    = random_request(MODE_ADD_MIRROR);
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            return r;
        end
        if (pick < 4) begin
            size = $urandom_range(1, 16);
        end else if (pick < 8) begin
            size = $urandom_range(1, 4096);
        end else begin
            size = $urandom_range(1, 65536);
        end
        if (sb.region_used > 0 && $urandom_range(0, 1)) begin
            base = sb.region_base[$urandom_range(0, sb.region_used - 1)];
        end else begin
            base = $urandom_range(0, 65535);
        end
        if (base + size > 65536) begin
            base = 65536 - size;
        end
        r.address    = t_addr'(base);
        r.source_end = t_addr'(base + size - 1);
        whole = $urandom_range(0, 3);
        rem   = $urandom_range(0, size - 1);
        if (whole == 0 && rem == 0) begin
            whole = 1;
        end
        span = whole * size + rem;
        if (span > 65536) begin
            span = 65536;
        end
        base = $urandom_range(0, 65536 - span);
        r.mirror_start = t_addr'(base);
        r.mirror_end   = t_addr'(base + span - 1);
        return r;
    endfunction

    // aim at mirror spans, region interiors and region edges, or anywhere
    function automatic t_request make_translate_request();
        t_request    r;
        int unsigned pick, k, base, lim;
        r    = random_request(($urandom_range(0, 7) == 0) ? MODE_TRANSLATE_ALIAS
                                                          : MODE_TRANSLATE);
        pick = $urandom_range(0, 9);
        if (pick < 4 && sb.mirror_used > 0) begin
            k = $urandom_range(0, sb.mirror_used - 1);
            r.address = t_addr'(sb.mirror_dst[k] + $urandom_range(0, sb.mirror_len[k] - 1));
        end else if (pick < 8 && sb.region_used > 0) begin
            k    = $urandom_range(0, sb.region_used - 1);
            base = sb.region_base[k];
            lim  = (sb.region_len[k] < 65536 - base) ? sb.region_len[k] : 65536 - base;
            if (pick == 7) begin
                r.address = $urandom_range(0, 1) ? t_addr'(base - 1)
                                                 : t_addr'(base + sb.region_len[k]);
            end else if (lim == 0) begin
                r.address = t_addr'(base);
            end else begin
                r.address = t_addr'(base + $urandom_range(0, lim - 1));
            end
        end
        return r;
    endfunction

    // offer one request and hold it until the transfer; valid stays up on back-to-back
    task automatic send_request(input t_request r);
        int unsigned gap;
        gap = ((requests_sent / 40) % 5 == 4) ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.mode         <= r.mode;
        in_ch.address      <= r.address;
        in_ch.region_size  <= r.region_size;
        in_ch.source_end   <= r.source_end;
        in_ch.mirror_start <= r.mirror_start;
        in_ch.mirror_end   <= r.mirror_end;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_request(r);
        requests_sent++;
    endtask

    // result side: random stalls, one long hold-off so the block backs up
    initial begin
        int unsigned stall;
        out_ch.ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            if (results_seen == HOLD_OFF_AT) begin
                stall = HOLD_OFF_CYCLES;
            end else if ((results_seen / 40) % 5 == 2) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 8);
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            sb.check_result('{status: out_ch.status, region_index: out_ch.region_index,
                              offset: out_ch.offset, folded_address: out_ch.folded_address});
            results_seen++;
        end
    end

    // watchdog
    initial begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < RUN_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // stimulus and end of run
    initial begin
        int unsigned item_no, roll;
        t_request    req;
        sb = new;
        i_rst_n            <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.mode         <= MODE_ADD_REGION;
        in_ch.address      <= '0;
        in_ch.region_size  <= '0;
        in_ch.source_end   <= '0;
        in_ch.mirror_start <= '0;
        in_ch.mirror_end   <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty tables: the address comes back unfolded and unmapped
        send_request(compose_request(MODE_TRANSLATE, 16'h1234, '0, '0, '0, '0));
        send_request(compose_request(MODE_TRANSLATE_ALIAS, 16'hFFFF, '0, '0, '0, '0));
        // inverted source, inverted span, both inverted
        send_request(compose_request(MODE_ADD_MIRROR, 16'h2000, '0, 16'h1FFF, 16'h5000,
                                     16'h5010));
        send_request(compose_request(MODE_ADD_MIRROR, 16'h2000, '0, 16'h2FFF, 16'h5000,
                                     16'h4FFF));
        send_request(compose_request(MODE_ADD_MIRROR, 16'hFFFF, '0, 16'h0000, 16'hFFFF,
                                     16'h0000));
        // zero-length region, a normal one, one running past the top, one at zero
        send_request(compose_request(MODE_ADD_REGION, 16'h1000, 16'h0000, '0, '0, '0));
        send_request(compose_request(MODE_ADD_REGION, 16'h1000, 16'h0100, '0, '0, '0));
        send_request(compose_request(MODE_ADD_REGION, 16'hFFFF, 16'hFFFF, '0, '0, '0));
        send_request(compose_request(MODE_ADD_REGION, 16'h0000, 16'h0800, '0, '0, '0));
        send_request(compose_request(MODE_TRANSLATE, 16'h1000, '0, '0, '0, '0));
        send_request(compose_request(MODE_TRANSLATE, 16'hFFFF, '0, '0, '0, '0));
        send_request(compose_request(MODE_TRANSLATE, 16'h0000, '0, '0, '0, '0));
        // two whole copies and a partial piece
        send_request(compose_request(MODE_ADD_MIRROR, 16'h1000, '0, 16'h10FF, 16'h4000,
                                     16'h4280));
        send_request(compose_request(MODE_TRANSLATE, 16'h4000, '0, '0, '0, '0));
        send_request(compose_request(MODE_TRANSLATE, 16'h4180, '0, '0, '0, '0));
        send_request(compose_request(MODE_TRANSLATE, 16'h4280, '0, '0, '0, '0));
        send_request(compose_request(MODE_TRANSLATE, 16'h4281, '0, '0, '0, '0));
        // full 64k source folded onto a short span at the top
        send_request(compose_request(MODE_ADD_MIRROR, 16'h0000, '0, 16'hFFFF, 16'hFFF0,
                                     16'hFFFF));
        send_request(compose_request(MODE_TRANSLATE, 16'hFFFF, '0, '0, '0, '0));
        send_request(compose_request(MODE_TRANSLATE_ALIAS, 16'hFFF0, '0, '0, '0, '0));
        send_request(compose_request(MODE_TRANSLATE, 16'h10FF, '0, '0, '0, '0));
        send_request(compose_request(MODE_TRANSLATE, 16'h1100, '0, '0, '0, '0));

        // random traffic, mostly translations; both tables fill along the way
        for (item_no = 0; item_no < RANDOM_ITEMS; item_no++) begin
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                req = make_region_request();
            end else if (roll < 7) begin
                req = make_mirror_request();
            end else begin
                req = make_translate_request();
            end
            send_request(req);
        end
        in_ch.valid <= 1'b0;

        // wait for the last results, then watch for strays
        while (sb.owed_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
